/* rtl/i2cms_pkg.sv */
// Shared types and codes for the I2C master event sequencer.
package i2cms_pkg;

   // action codes
   typedef enum logic [2:0] {
      ACT_START_TX = 3'd0,
      ACT_START_RX = 3'd1,
      ACT_LOAD     = 3'd2,
      ACT_EVENT    = 3'd3,
      ACT_ERROR    = 3'd4
   } action_type;

   // event flag bit positions
   localparam int EV_SB    = 0;
   localparam int EV_ADDR  = 1;
   localparam int EV_BTF   = 2;
   localparam int EV_STOPF = 3;
   localparam int EV_RXNE  = 4;
   localparam int EV_TXE   = 5;

   localparam int NUM_ERRORS = 6;
   localparam int ER_AF      = 2;

   localparam logic [1:0] ACK_NONE    = 2'd0;
   localparam logic [1:0] ACK_DISABLE = 2'd1;
   localparam logic [1:0] ACK_ENABLE  = 2'd2;

   localparam logic [1:0] FC_NONE  = 2'd0;
   localparam logic [1:0] FC_ADDR  = 2'd1;
   localparam logic [1:0] FC_STOPF = 2'd2;
   localparam logic [1:0] FC_ERROR = 2'd3;

   localparam logic [2:0] SN_NONE     = 3'd0;
   localparam logic [2:0] SN_RX_DONE  = 3'd1;
   localparam logic [2:0] SN_RX_DATA  = 3'd2;
   localparam logic [2:0] SN_TX_REQ   = 3'd3;
   localparam logic [2:0] SN_TX_DONE  = 3'd4;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RUNNING  = 4'd1;
   localparam logic [3:0] ST_FINISHED = 4'd2;
   localparam int         ST_ERR_BASE = 3;

   // register map (index = paddr[3:2])
   localparam int         CSR_ADDR_W = 4;
   localparam logic [1:0] REG_SLAVE_ADDRESS   = 2'd0;
   localparam logic [1:0] REG_TRANSFER_LENGTH = 2'd1;
   localparam logic [1:0] REG_REPEATED_START  = 2'd2;

   typedef struct packed {
      logic [6:0] slave_address;
      logic [8:0] transfer_length;
      logic       repeated_start;
   } cfg_type;

   typedef struct packed {
      logic [2:0] action;
      logic [5:0] event_flags;
      logic [5:0] error_flags;
      logic       is_master;
      logic [7:0] rx_byte;
      logic [7:0] load_index;
      logic [7:0] load_byte;
   } item_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] write_byte;
      logic       set_start;
      logic       set_stop;
      logic [1:0] ack_action;
      logic [1:0] flag_clear;
      logic [2:0] cleared_error;
      logic [2:0] slave_notice;
      logic [3:0] run_status;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [7:0] rx_index;
   } result_type;

endpackage

/* rtl/i2cms_req_if.sv */
// Request channel: one action word per handshake.
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [5:0] event_flags;
   logic [5:0] error_flags;
   logic       is_master;
   logic [7:0] rx_byte;
   logic [7:0] load_index;
   logic [7:0] load_byte;

   modport source (
      output valid, action, event_flags, error_flags, is_master, rx_byte,
             load_index, load_byte,
      input  ready
   );
   modport sink (
      input  valid, action, event_flags, error_flags, is_master, rx_byte,
             load_index, load_byte,
      output ready
   );
endinterface

/* rtl/i2cms_rsp_if.sv */
// Response channel: one result word per handshake.
interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       write_valid;
   logic [7:0] write_byte;
   logic       set_start;
   logic       set_stop;
   logic [1:0] ack_action;
   logic [1:0] flag_clear;
   logic [2:0] cleared_error;
   logic [2:0] slave_notice;
   logic [3:0] run_status;
   logic       rx_valid;
   logic [7:0] rx_data;
   logic [7:0] rx_index;

   modport source (
      output valid, write_valid, write_byte, set_start, set_stop, ack_action,
             flag_clear, cleared_error, slave_notice, run_status, rx_valid,
             rx_data, rx_index,
      input  ready
   );
   modport sink (
      input  valid, write_valid, write_byte, set_start, set_stop, ack_action,
             flag_clear, cleared_error, slave_notice, run_status, rx_valid,
             rx_data, rx_index,
      output ready
   );
endinterface

/* rtl/i2cms_ram.sv */
// Generic single-port-write, registered-read RAM.
module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/i2cms_csr.sv */
// APB configuration registers.
module i2cms_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [i2cms_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output i2cms_pkg::cfg_type                 cfg
);
   import i2cms_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] idx;

   assign idx    = paddr[3:2];
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            REG_SLAVE_ADDRESS:   cfg_in.slave_address   = pwdata[6:0];
            REG_TRANSFER_LENGTH: cfg_in.transfer_length = pwdata[8:0];
            REG_REPEATED_START:  cfg_in.repeated_start  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address   <= 7'd0;
         cfg_ff.transfer_length <= 9'd1;
         cfg_ff.repeated_start  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_SLAVE_ADDRESS:   prdata = {25'd0, cfg_ff.slave_address};
         REG_TRANSFER_LENGTH: prdata = {23'd0, cfg_ff.transfer_length};
         REG_REPEATED_START:  prdata = {31'd0, cfg_ff.repeated_start};
         default:             prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

/* rtl/i2cms_seq.sv */
// Transfer state, transmit buffer and per-word decode into a result.
module i2cms_seq #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  i2cms_pkg::item_type             item,
   input  logic [$clog2(BUFFER_DEPTH)-1:0] load_addr,
   input  i2cms_pkg::cfg_type              cfg,
   output i2cms_pkg::result_type           res
);
   import i2cms_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic [8:0]    byte_index_ff, byte_index_in;
   logic [AW-1:0] ptr_ff, ptr_in, ptr_next;
   logic          dir_rx_ff, dir_rx_in;
   logic [3:0]    status_ff, status_in;
   logic          byp_ff;
   logic [7:0]    byp_data_ff;
   logic          we;
   logic [7:0]    ram_rdata, buf_data;
   logic [9:0]    bi_plus1, bi_plus2, len_w;
   logic          found;

   // read address tracks the next buffer position; same-cycle writes bypass
   i2cms_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
      .clock (clock),
      .we    (we),
      .waddr (load_addr),
      .wdata (item.load_byte),
      .raddr (ptr_in),
      .rdata (ram_rdata)
   );

   assign buf_data = byp_ff ? byp_data_ff : ram_rdata;
   assign bi_plus1 = {1'b0, byte_index_ff} + 10'd1;
   assign bi_plus2 = {1'b0, byte_index_ff} + 10'd2;
   assign len_w    = {1'b0, cfg.transfer_length};
   assign ptr_next = (ptr_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   always_comb begin
      res           = '0;
      byte_index_in = byte_index_ff;
      ptr_in        = ptr_ff;
      dir_rx_in     = dir_rx_ff;
      status_in     = status_ff;
      we            = 1'b0;
      found         = 1'b0;
      if (go) begin
         unique case (item.action)
            ACT_START_TX, ACT_START_RX: begin
               dir_rx_in     = item.action[0];
               byte_index_in = 9'd0;
               ptr_in        = '0;
               status_in     = ST_RUNNING;
               res.set_start = 1'b1;
            end
            ACT_LOAD: we = 1'b1;
            ACT_EVENT: begin
               priority if (item.event_flags[EV_SB]) begin
                  res.write_valid = 1'b1;
                  res.write_byte  = {cfg.slave_address, dir_rx_ff};
               end else if (item.event_flags[EV_ADDR]) begin
                  if (item.is_master && dir_rx_ff && cfg.transfer_length == 9'd1) begin
                     res.ack_action = ACK_DISABLE;
                  end
                  res.flag_clear = FC_ADDR;
               end else if (item.event_flags[EV_BTF]) begin
                  if (!dir_rx_ff && byte_index_ff == cfg.transfer_length) begin
                     res.set_stop = !cfg.repeated_start;
                     status_in    = ST_FINISHED;
                  end
               end else if (item.event_flags[EV_STOPF]) begin
                  res.flag_clear   = FC_STOPF;
                  res.slave_notice = SN_RX_DONE;
               end else if (item.event_flags[EV_RXNE]) begin
                  if (!item.is_master) begin
                     res.slave_notice = SN_RX_DATA;
                  end else if (byte_index_ff < cfg.transfer_length) begin
                     if (bi_plus2 == len_w) res.ack_action = ACK_DISABLE;
                     res.set_stop  = (bi_plus1 == len_w) && !cfg.repeated_start;
                     res.rx_valid  = 1'b1;
                     res.rx_data   = item.rx_byte;
                     res.rx_index  = byte_index_ff[7:0];
                     byte_index_in = bi_plus1[8:0];
                     ptr_in        = ptr_next;
                     // last byte: done, ACK back on for the next transfer
                     if (bi_plus1 == len_w) begin
                        status_in      = ST_FINISHED;
                        res.ack_action = ACK_ENABLE;
                     end
                  end
               end else if (item.event_flags[EV_TXE]) begin
                  if (!item.is_master) begin
                     res.slave_notice = SN_TX_REQ;
                  end else if (byte_index_ff < cfg.transfer_length) begin
                     res.write_valid = 1'b1;
                     res.write_byte  = buf_data;
                     byte_index_in   = bi_plus1[8:0];
                     ptr_in          = ptr_next;
                  end
               end
            end
            ACT_ERROR: begin
               for (int k = 0; k < NUM_ERRORS; k++) begin
                  if (!found && item.error_flags[k]) begin
                     found             = 1'b1;
                     res.flag_clear    = FC_ERROR;
                     res.cleared_error = 3'(k + 1);
                     if (k == ER_AF && !item.is_master) begin
                        res.slave_notice = SN_TX_DONE;
                     end else begin
                        status_in = 4'(k + ST_ERR_BASE);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      res.run_status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 9'd0;
         ptr_ff        <= '0;
         dir_rx_ff     <= 1'b0;
         status_ff     <= ST_IDLE;
         byp_ff        <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         ptr_ff        <= ptr_in;
         dir_rx_ff     <= dir_rx_in;
         status_ff     <= status_in;
         byp_ff        <= we && (load_addr == ptr_in);
      end
      byp_data_ff <= item.load_byte;
   end
endmodule

/* rtl/i2c_master_event_sequencer.sv */
// Top level of the I2C master event sequencer: channel stages and register port.
//
//  channel | direction | handshake               | carries
//  req_ch  | in        | valid/ready             | one action word
//  rsp_ch  | out       | valid/ready             | one result word per action
//  csr_*   | in        | APB psel/penable, pready=1 | slave address, length, rep start
//
// A word is decoded while it sits in the input register and its result is
// registered in the result register when the decode step proceeds. One word a
// cycle is sustained while rsp_ch.ready is high; the transmit buffer read is
// issued ahead from the next buffer position, so TXE does not stall.
// Synchronous reset clears control state; buffer contents stay undefined.
// A stalled result holds the decode step, which backs up into req_ch.ready.
module i2c_master_event_sequencer #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   i2cms_req_if.sink                        req_ch,
   i2cms_rsp_if.source                      rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [i2cms_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import i2cms_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   cfg_type       cfg;
   item_type      item_ff;
   logic [AW-1:0] load_addr_ff;
   logic          a_valid_ff, a_valid_in;
   result_type    out_ff, res;
   logic          out_valid_ff, out_valid_in;
   logic          go, accept;
   logic [7:0]    mod_r;

   i2cms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   i2cms_seq #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .item      (item_ff),
      .load_addr (load_addr_ff),
      .cfg       (cfg),
      .res       (res)
   );

   assign go           = a_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !a_valid_ff || go;
   assign accept       = req_ch.valid && req_ch.ready;
   assign a_valid_in   = accept || (a_valid_ff && !go);
   assign out_valid_in = go || (out_valid_ff && !rsp_ch.ready);

   // load position modulo the buffer depth, by shifted compare-subtract
   always_comb begin
      mod_r = req_ch.load_index;
      for (int k = 7; k >= 0; k--) begin
         if ({24'd0, mod_r} >= (BUFFER_DEPTH << k)) begin
            mod_r = mod_r - 8'(BUFFER_DEPTH << k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         item_ff.action      <= req_ch.action;
         item_ff.event_flags <= req_ch.event_flags;
         item_ff.error_flags <= req_ch.error_flags;
         item_ff.is_master   <= req_ch.is_master;
         item_ff.rx_byte     <= req_ch.rx_byte;
         item_ff.load_index  <= req_ch.load_index;
         item_ff.load_byte   <= req_ch.load_byte;
         load_addr_ff        <= AW'(mod_r);
      end
      if (go) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.write_valid   = out_ff.write_valid;
   assign rsp_ch.write_byte    = out_ff.write_byte;
   assign rsp_ch.set_start     = out_ff.set_start;
   assign rsp_ch.set_stop      = out_ff.set_stop;
   assign rsp_ch.ack_action    = out_ff.ack_action;
   assign rsp_ch.flag_clear    = out_ff.flag_clear;
   assign rsp_ch.cleared_error = out_ff.cleared_error;
   assign rsp_ch.slave_notice  = out_ff.slave_notice;
   assign rsp_ch.run_status    = out_ff.run_status;
   assign rsp_ch.rx_valid      = out_ff.rx_valid;
   assign rsp_ch.rx_data       = out_ff.rx_data;
   assign rsp_ch.rx_index      = out_ff.rx_index;

   // input stage only refuses a word when both stages are full and stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (a_valid_ff && out_valid_ff && !rsp_ch.ready))
      else $error("request stalled without a full, stalled pipeline");

   // a decoded word always lands in the result register
   a_go_lands: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_ch.valid)
      else $error("decoded word lost before the result register");

   // a result never both writes a byte and delivers a received one
   a_tx_rx_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.write_valid && rsp_ch.rx_valid))
      else $error("write and receive delivered in one result");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the I2C master event sequencer: directed and random words.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cms_pkg::*;

   localparam int LIMIT       = 200000;
   localparam int MAX_PRINTED = 30;
   localparam int HOLD_CYCLES = 80;

   // action codes the block ignores
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   localparam logic [5:0] F_NONE  = 6'd0;
   localparam logic [5:0] F_SB    = 6'(1 << EV_SB);
   localparam logic [5:0] F_ADDR  = 6'(1 << EV_ADDR);
   localparam logic [5:0] F_BTF   = 6'(1 << EV_BTF);
   localparam logic [5:0] F_STOPF = 6'(1 << EV_STOPF);
   localparam logic [5:0] F_RXNE  = 6'(1 << EV_RXNE);
   localparam logic [5:0] F_TXE   = 6'(1 << EV_TXE);
   localparam logic [5:0] F_AF    = 6'(1 << ER_AF);

   // receiver behaviour
   localparam int RSP_ALWAYS       = 0;
   localparam int RSP_COIN         = 1;
   localparam int RSP_EVERY_FOURTH = 2;
   localparam int RSP_MOSTLY       = 3;

   class sequencer_model;
      logic [7:0] tx_buffer [256];
      bit         loaded [256];
      logic [8:0] byte_pos;
      bit         dir_rx;
      logic [3:0] status;
      cfg_type    cfg;
      result_type expected_results [$];
      int         mismatches;
      int         checked;

      function new();
         byte_pos = '0;
         dir_rx = 1'b0;
         status = ST_IDLE;
         cfg.slave_address = '0;
         cfg.transfer_length = 9'd1;
         cfg.repeated_start = 1'b0;
         mismatches = 0;
         checked = 0;
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      function void set_config(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_SLAVE_ADDRESS:   cfg.slave_address   = value[6:0];
            REG_TRANSFER_LENGTH: cfg.transfer_length = value[8:0];
            REG_REPEATED_START:  cfg.repeated_start  = value[0];
            default: ;
         endcase
      endfunction

      // lowest set bit is the highest priority; -1 when nothing is pending
      function int first_set(logic [5:0] flags);
         for (int k = 0; k < 6; k++)
            if (flags[k]) return k;
         return -1;
      endfunction

      // a TXE must never read a buffer entry that was never loaded: load it instead
      function item_type make_safe(item_type w);
         item_type s;
         s = w;
         if (w.action == ACT_EVENT && first_set(w.event_flags) == EV_TXE && w.is_master
             && byte_pos < cfg.transfer_length && !loaded[byte_pos[7:0]]) begin
            s.action = ACT_LOAD;
            s.load_index = byte_pos[7:0];
         end
         return s;
      endfunction

      function result_type predict_result(item_type w);
         result_type r;
         int hit;
         int len;
         int pos;
         r = '0;
         len = cfg.transfer_length;
         pos = byte_pos;
         case (w.action)
            ACT_START_TX, ACT_START_RX: begin
               dir_rx = (w.action == ACT_START_RX);
               byte_pos = '0;
               status = ST_RUNNING;
               r.set_start = 1'b1;
            end
            ACT_LOAD: begin
               tx_buffer[w.load_index] = w.load_byte;
               loaded[w.load_index] = 1'b1;
            end
            ACT_EVENT: begin
               hit = first_set(w.event_flags);
               case (hit)
                  EV_SB: begin
                     r.write_valid = 1'b1;
                     r.write_byte = {cfg.slave_address, dir_rx};
                  end
                  EV_ADDR: begin
                     if (w.is_master && dir_rx && len == 1) r.ack_action = ACK_DISABLE;
                     r.flag_clear = FC_ADDR;
                  end
                  EV_BTF: begin
                     if (!dir_rx && pos == len) begin
                        if (!cfg.repeated_start) r.set_stop = 1'b1;
                        status = ST_FINISHED;
                     end
                  end
                  EV_STOPF: begin
                     r.flag_clear = FC_STOPF;
                     r.slave_notice = SN_RX_DONE;
                  end
                  EV_RXNE: begin
                     if (!w.is_master) begin
                        r.slave_notice = SN_RX_DATA;
                     end else if (pos < len) begin
                        if (pos + 2 == len) r.ack_action = ACK_DISABLE;
                        if (pos + 1 == len && !cfg.repeated_start) r.set_stop = 1'b1;
                        r.rx_valid = 1'b1;
                        r.rx_data = w.rx_byte;
                        r.rx_index = byte_pos[7:0];
                        byte_pos = byte_pos + 9'd1;
                        if (byte_pos == cfg.transfer_length) begin
                           status = ST_FINISHED;
                           r.ack_action = ACK_ENABLE;
                        end
                     end
                  end
                  EV_TXE: begin
                     if (!w.is_master) begin
                        r.slave_notice = SN_TX_REQ;
                     end else if (pos < len) begin
                        r.write_valid = 1'b1;
                        r.write_byte = tx_buffer[byte_pos[7:0]];
                        byte_pos = byte_pos + 9'd1;
                     end
                  end
                  default: ;
               endcase
            end
            ACT_ERROR: begin
               hit = first_set(w.error_flags);
               if (hit >= 0) begin
                  r.flag_clear = FC_ERROR;
                  r.cleared_error = 3'(hit + 1);
                  // acknowledge failure in slave mode only ends the slave transmission
                  if (hit == ER_AF && !w.is_master) r.slave_notice = SN_TX_DONE;
                  else status = 4'(ST_ERR_BASE + hit);
               end
            end
            default: ;
         endcase
         r.run_status = status;
         return r;
      endfunction

      function void note_request(item_type w);
         expected_results.push_back(predict_result(w));
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("word %0d %s: got %0h, wanted %0h", checked, name, got, want));
      endtask

      task check_response(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report("result word with nothing outstanding");
            return;
         end
         want = expected_results.pop_front();
         checked++;
         compare_field("write_valid", got.write_valid, want.write_valid);
         compare_field("write_byte", got.write_byte, want.write_byte);
         compare_field("set_start", got.set_start, want.set_start);
         compare_field("set_stop", got.set_stop, want.set_stop);
         compare_field("ack_action", got.ack_action, want.ack_action);
         compare_field("flag_clear", got.flag_clear, want.flag_clear);
         compare_field("cleared_error", got.cleared_error, want.cleared_error);
         compare_field("slave_notice", got.slave_notice, want.slave_notice);
         compare_field("run_status", got.run_status, want.run_status);
         compare_field("rx_valid", got.rx_valid, want.rx_valid);
         compare_field("rx_data", got.rx_data, want.rx_data);
         compare_field("rx_index", got.rx_index, want.rx_index);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   i2cms_req_if req ();
   i2cms_rsp_if rsp ();

   i2c_master_event_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sequencer_model board = new();

   int     words_sent;
   int     transfers_tx;
   int     transfers_rx;
   int     settings_run;
   int     hold_request;
   int     burst_left;
   bit     valid_high;
   bit     sender_eager;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", LIMIT,
               board.expected_results.size());
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.write_valid   = rsp.write_valid;
         got.write_byte    = rsp.write_byte;
         got.set_start     = rsp.set_start;
         got.set_stop      = rsp.set_stop;
         got.ack_action    = rsp.ack_action;
         got.flag_clear    = rsp.flag_clear;
         got.cleared_error = rsp.cleared_error;
         got.slave_notice  = rsp.slave_notice;
         got.run_status    = rsp.run_status;
         got.rx_valid      = rsp.rx_valid;
         got.rx_data       = rsp.rx_data;
         got.rx_index      = rsp.rx_index;
         board.check_response(got);
      end
   end

   // receiver: changes its stall pattern on its own, plus long hold-offs on request
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      int tick;
      mode = RSP_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(RSP_ALWAYS, RSP_MOSTLY);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            case (mode)
               RSP_ALWAYS:       rsp.ready <= 1'b1;
               RSP_COIN:         rsp.ready <= ($urandom_range(0, 1) == 1);
               RSP_EVERY_FOURTH: rsp.ready <= (tick % 4 != 0);
               default:          rsp.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   function item_type word(logic [2:0] act, logic [5:0] ev, logic [5:0] er, logic master,
                           logic [7:0] rx, logic [7:0] li, logic [7:0] lb);
      item_type w;
      w.action = act;
      w.event_flags = ev;
      w.error_flags = er;
      w.is_master = master;
      w.rx_byte = rx;
      w.load_index = li;
      w.load_byte = lb;
      return w;
   endfunction

   function item_type noise_word();
      return word(3'($urandom), 6'($urandom), 6'($urandom), 1'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
   endfunction

   function item_type event_word(logic [5:0] ev, logic master);
      return word(ACT_EVENT, ev, 6'($urandom), master, 8'($urandom), 8'($urandom),
                  8'($urandom));
   endfunction

   // flag at pos set, random lower-priority flags above it, nothing of higher priority
   function logic [5:0] pending_from(int pos);
      logic [5:0] above;
      above = 6'($urandom) << (pos + 1);
      return above | 6'(1 << pos);
   endfunction

   task lower_valid();
      if (valid_high) begin
         req.valid <= 1'b0;
         valid_high = 1'b0;
      end
   endtask

   task send_word(item_type w);
      item_type s;
      int gap;
      s = board.make_safe(w);
      req.valid       <= 1'b1;
      req.action      <= s.action;
      req.event_flags <= s.event_flags;
      req.error_flags <= s.error_flags;
      req.is_master   <= s.is_master;
      req.rx_byte     <= s.rx_byte;
      req.load_index  <= s.load_index;
      req.load_byte   <= s.load_byte;
      valid_high = 1'b1;
      do @(posedge clock); while (!req.ready);
      board.note_request(s);
      if (s.action <= ACT_ERROR) words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 12);
         gap = sender_eager ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            lower_valid();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task write_register(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_config(idx, value);
   endtask

   // registers only change with the block drained
   task configure(logic [6:0] address, logic [8:0] length, logic repeat_stop_off);
      lower_valid();
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_register(REG_SLAVE_ADDRESS, 32'(address));
      write_register(REG_TRANSFER_LENGTH, 32'(length));
      write_register(REG_REPEATED_START, 32'(repeat_stop_off));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_run++;
   endtask

   // loads if transmit, start, SB, ADDR, data events, BTF or STOPF, with the odd stray word
   task run_transfer(bit rx, int data_words);
      int len;
      int preload;
      int i;
      logic master;
      len = board.cfg.transfer_length;
      if (rx) begin
         transfers_rx++;
      end else begin
         transfers_tx++;
         preload = (data_words < len) ? data_words : len;
         for (i = 0; i < preload && i < 256; i++)
            if ($urandom_range(0, 3) != 0)
               send_word(word(ACT_LOAD, 6'($urandom), 6'($urandom), 1'($urandom),
                              8'($urandom), 8'(i), 8'($urandom)));
      end
      master = ($urandom_range(0, 7) != 0);
      send_word(word(rx ? ACT_START_RX : ACT_START_TX, 6'($urandom), 6'($urandom),
                     1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      send_word(event_word(pending_from(EV_SB), master));
      send_word(event_word(pending_from(EV_ADDR), master));
      for (i = 0; i < data_words; i++) begin
         if ($urandom_range(0, 29) == 0)
            send_word(noise_word());
         else if ($urandom_range(0, 39) == 0)
            send_word(word(ACT_ERROR, 6'($urandom), pending_from($urandom_range(0, 5)),
                           1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
         else
            send_word(event_word(pending_from(rx ? EV_RXNE : EV_TXE),
                                 $urandom_range(0, 15) != 0));
      end
      send_word(event_word(pending_from(rx ? EV_STOPF : EV_BTF), master));
   endtask

   initial begin
      int phase;
      int goal;
      int dw;
      int k;
      logic [6:0] addr;
      logic [8:0] len;
      logic rs;
      words_sent = 0;
      transfers_tx = 0;
      transfers_rx = 0;
      settings_run = 0;
      hold_request = 0;
      burst_left = 0;
      valid_high = 1'b0;
      sender_eager = 1'b0;
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.action      <= ACT_START_TX;
      req.event_flags <= F_NONE;
      req.error_flags <= F_NONE;
      req.is_master   <= 1'b0;
      req.rx_byte     <= 8'h00;
      req.load_index  <= 8'h00;
      req.load_byte   <= 8'h00;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= 32'h0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset settings (length 1, stop enabled)
      send_word(word(ACT_LOAD, F_NONE, F_NONE, 1'b1, 8'h00, 8'h00, 8'hFF));
      send_word(word(ACT_LOAD, '1, '1, 1'b0, 8'hFF, 8'hFF, 8'h00));
      send_word(word(ACT_SPARE_FIRST, '1, '1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
      send_word(word(ACT_SPARE_LAST, '1, '1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
      send_word(word(ACT_EVENT, F_NONE, '1, 1'b1, 8'hFF, 8'h00, 8'h00));
      send_word(word(ACT_ERROR, '1, F_NONE, 1'b1, 8'h00, 8'h00, 8'h00));
      // one-byte transmit, then a TXE past the end
      send_word(word(ACT_START_TX, F_NONE, F_NONE, 1'b1, 8'h00, 8'h00, 8'h00));
      send_word(event_word('1, 1'b1));
      send_word(event_word(F_ADDR | F_BTF, 1'b1));
      send_word(event_word(F_TXE, 1'b1));
      send_word(event_word(F_TXE, 1'b1));
      send_word(event_word(F_BTF, 1'b1));
      // one-byte receive, a dropped byte, then slave-mode notices
      send_word(word(ACT_START_RX, F_NONE, F_NONE, 1'b1, 8'h00, 8'h00, 8'h00));
      send_word(event_word(F_SB, 1'b1));
      send_word(event_word(F_ADDR, 1'b1));
      send_word(word(ACT_EVENT, F_RXNE, F_NONE, 1'b1, 8'hFF, 8'h00, 8'h00));
      send_word(word(ACT_EVENT, F_RXNE, F_NONE, 1'b1, 8'h5A, 8'h00, 8'h00));
      send_word(word(ACT_EVENT, F_RXNE, F_NONE, 1'b0, 8'h00, 8'h00, 8'h00));
      send_word(event_word(F_TXE, 1'b0));
      send_word(event_word(F_STOPF, 1'b1));
      for (k = 0; k < NUM_ERRORS; k++)
         send_word(word(ACT_ERROR, F_NONE, 6'(1 << k), 1'b1, 8'h00, 8'h00, 8'h00));
      send_word(word(ACT_ERROR, F_NONE, F_AF, 1'b0, 8'h00, 8'h00, 8'h00));

      goal = words_sent;
      for (phase = 0; phase < 12; phase++) begin
         addr = 7'($urandom);
         rs = 1'($urandom);
         len = 9'($urandom_range(1, 8));
         case (phase)
            0: begin
               addr = 7'h00;
               len = 9'd1;
               rs = 1'b0;
            end
            1: begin
               addr = 7'h7F;
               len = 9'd256;
               rs = 1'b1;
            end
            2: begin
               len = 9'd2;
               rs = 1'b0;
            end
            3: begin
               len = 9'd3;
               rs = 1'b1;
            end
            4: len = 9'd0;
            5: len = 9'h1FF;
            default: ;
         endcase
         configure(addr, len, rs);
         sender_eager = ($urandom_range(0, 3) == 0);
         if (phase == 3 || phase == 8) begin
            // receiver holds off while the sender keeps offering back to back
            sender_eager = 1'b1;
            hold_request = HOLD_CYCLES;
         end
         goal += (len > 8) ? 300 : 95;
         // long receives run toward the end of a 256-byte transfer and can wrap rx_index
         if (len > 8) run_transfer(1'b1, (len == 9'd256) ? 257 : 290);
         while (words_sent < goal) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4)) send_word(noise_word());
            end else begin
               if (len > 8) dw = $urandom_range(1, 12);
               else if ($urandom_range(0, 3) == 0) dw = $urandom_range(0, len + 2);
               else dw = len + $urandom_range(0, 1);
               run_transfer(1'($urandom), dw);
            end
         end
      end

      lower_valid();
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("checked %0d result words from %0d action words over %0d register settings",
               board.checked, words_sent, settings_run);
      $display("%0d transmit and %0d receive transfers, lengths 0 to 511, two receiver holds",
               transfers_tx, transfers_rx);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* i2c_master_event_sequencer.f */
rtl/i2cms_pkg.sv
rtl/i2cms_req_if.sv
rtl/i2cms_rsp_if.sv
rtl/i2cms_ram.sv
rtl/i2cms_csr.sv
rtl/i2cms_seq.sv
rtl/i2c_master_event_sequencer.sv
tb/testbench.sv
